// ----- rtl/core/tpfq_pkg.sv -----
// ----------------------------------------------------------------------------
// tpfq_pkg
// shared constants, register codes and the result record of the trail point
// fade queue
// ----------------------------------------------------------------------------
package tpfq_pkg;

  localparam int POOL_DEPTH_DEF  = 64;
  localparam int COORD_WIDTH_DEF = 32;

  // fixed field widths
  localparam int TIME_W     = 31;   // unsigned q15.16 time values
  localparam int TIMER_W    = 32;   // emit timer, saturating
  localparam int REM_W      = 33;   // signed remaining fade time
  localparam int SLOT_W     = 6;
  localparam int COUNT_W    = 7;
  localparam int OUT_DATA_W = 32;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FADE_TIME    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = CFG_IDX_W'(1);

  localparam logic [TIME_W-1:0] FADE_TIME_RESET    = TIME_W'(65536);
  localparam logic [TIME_W-1:0] MIN_INTERVAL_RESET = TIME_W'(1024);

  // function codes carried in tuser
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_ADD  = 1'b1;

  typedef struct packed {
    logic [SLOT_W-1:0]  head_slot;
    logic               head_valid;
    logic [COUNT_W-1:0] alive_count;
    logic [COUNT_W-1:0] removed_count;
    logic [SLOT_W-1:0]  slot;
    logic               accepted;
  } result_t;

endpackage

// ----- rtl/core/tpfq_ram.sv -----
// ----------------------------------------------------------------------------
// tpfq_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module tpfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/tpfq_seq.sv -----
// ----------------------------------------------------------------------------
// tpfq_seq
// sequencer around the entry and link memories: tick sweep, head unlink
// walk, free slot search and insert at the tail
// ----------------------------------------------------------------------------
module tpfq_seq #(
  parameter int POOL_DEPTH  = tpfq_pkg::POOL_DEPTH_DEF,
  parameter int COORD_WIDTH = tpfq_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [tpfq_pkg::TIME_W-1:0]   fade_time,
  input  logic [tpfq_pkg::TIME_W-1:0]   min_interval,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic                          func,
  input  logic [tpfq_pkg::TIME_W-1:0]   dt,
  input  logic [COORD_WIDTH-1:0]        pt_x,
  input  logic [COORD_WIDTH-1:0]        pt_y,
  input  logic [COORD_WIDTH-1:0]        pt_z,
  output logic                          res_valid,
  input  logic                          res_ready,
  output tpfq_pkg::result_t             res
);

  import tpfq_pkg::*;

  localparam int IDX_W   = $clog2(POOL_DEPTH);
  localparam int CNT_W   = $clog2(POOL_DEPTH + 1);
  localparam int REM_LSB = 1;
  localparam int REM_MSB = REM_LSB + REM_W - 1;
  localparam int ENTRY_W = 1 + REM_W + 3 * COORD_WIDTH;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(POOL_DEPTH);
  localparam logic [CNT_W-1:0] LAST_IDX  = CNT_W'(POOL_DEPTH - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_TICK  = 3'd2;
  localparam logic [2:0] S_WALK0 = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_SRCH  = 3'd5;
  localparam logic [2:0] S_PUT   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]             state;
  logic [CNT_W-1:0]       idx;
  logic                   pend;
  logic [IDX_W-1:0]       pend_addr;
  logic [IDX_W-1:0]       head;
  logic [IDX_W-1:0]       tail;
  logic [CNT_W-1:0]       count;
  logic [TIMER_W-1:0]     timer;
  logic [CNT_W-1:0]       removed;
  logic                   acc;
  logic                   first;
  logic [IDX_W-1:0]       put_slot;
  logic [TIME_W-1:0]      dt_q;
  logic [COORD_WIDTH-1:0] x_q;
  logic [COORD_WIDTH-1:0] y_q;
  logic [COORD_WIDTH-1:0] z_q;

  // entry word: live bit, remaining time, x, y, z from the lowest bit up
  logic               e_we;
  logic [IDX_W-1:0]   e_waddr;
  logic [ENTRY_W-1:0] e_wdata;
  logic [IDX_W-1:0]   e_raddr;
  logic [ENTRY_W-1:0] e_rdata;
  logic               l_we;
  logic [IDX_W-1:0]   l_waddr;
  logic [IDX_W-1:0]   l_wdata;
  logic [IDX_W-1:0]   l_raddr;
  logic [IDX_W-1:0]   l_rdata;

  logic [REM_W:0]     rem_diff;
  logic [REM_W-1:0]   rem_new;
  logic [TIMER_W:0]   timer_sum;
  logic [TIMER_W-1:0] timer_tick;
  logic               add_ok;

  logic [IDX_W+SLOT_W-1:0]  slot_ext;
  logic [IDX_W+SLOT_W-1:0]  head_ext;
  logic [CNT_W+COUNT_W-1:0] removed_ext;
  logic [CNT_W+COUNT_W-1:0] alive_ext;

  tpfq_ram #(.WIDTH(ENTRY_W), .DEPTH(POOL_DEPTH)) u_entry_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  tpfq_ram #(.WIDTH(IDX_W), .DEPTH(POOL_DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  // remaining time minus dt, held at -2^32
  assign rem_diff = {e_rdata[REM_MSB], e_rdata[REM_MSB:REM_LSB]} - {3'b000, dt_q};
  assign rem_new  = (rem_diff[REM_W:REM_W-1] == 2'b10) ? {1'b1, {(REM_W-1){1'b0}}}
                                                       : rem_diff[REM_W-1:0];

  assign timer_sum  = {1'b0, timer} + {2'b00, dt};
  assign timer_tick = timer_sum[TIMER_W] ? {TIMER_W{1'b1}} : timer_sum[TIMER_W-1:0];
  assign add_ok     = (timer >= {1'b0, min_interval}) || (count == '0);

  always_comb begin
    e_we    = 1'b0;
    e_waddr = pend_addr;
    e_wdata = '0;
    e_raddr = idx[IDX_W-1:0];
    l_we    = 1'b0;
    l_waddr = tail;
    l_wdata = put_slot;
    l_raddr = idx[IDX_W-1:0];
    case (state)
      S_CLEAR: begin
        e_we    = 1'b1;
        e_waddr = idx[IDX_W-1:0];
      end
      S_TICK: begin
        if (pend && e_rdata[0]) begin
          e_we    = 1'b1;
          e_wdata = {e_rdata[ENTRY_W-1:REM_MSB+1], rem_new, 1'b1};
        end
      end
      S_WALK0: begin
        e_raddr = head;
        l_raddr = head;
      end
      S_WALK: begin
        // follow the link while the old head is retired
        e_raddr = l_rdata;
        l_raddr = l_rdata;
        if (e_rdata[REM_MSB]) begin
          e_we    = 1'b1;
          e_waddr = head;
          e_wdata = {e_rdata[ENTRY_W-1:1], 1'b0};
        end
      end
      S_PUT: begin
        e_we    = 1'b1;
        e_waddr = put_slot;
        e_wdata = {z_q, y_q, x_q, {(REM_W-TIME_W){1'b0}}, fade_time, 1'b1};
        l_we    = !first;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      idx      <= '0;
      pend     <= 1'b0;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      timer    <= '0;
      removed  <= '0;
      acc      <= 1'b0;
      first    <= 1'b0;
      put_slot <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            dt_q     <= dt;
            x_q      <= pt_x;
            y_q      <= pt_y;
            z_q      <= pt_z;
            removed  <= '0;
            acc      <= 1'b0;
            put_slot <= '0;
            idx      <= '0;
            pend     <= 1'b0;
            if (func == FUNC_TICK) begin
              timer <= timer_tick;
              state <= S_TICK;
            end else if (add_ok) begin
              timer <= '0;
              if (count == '0) begin
                first <= 1'b1;
                state <= S_PUT;
              end else if (count < DEPTH_CNT) begin
                first <= 1'b0;
                state <= S_SRCH;
              end else begin
                state <= S_DONE;
              end
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_TICK: begin
          if (idx < DEPTH_CNT) begin
            idx       <= idx + 1'b1;
            pend      <= 1'b1;
            pend_addr <= idx[IDX_W-1:0];
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_WALK0;
            end
          end
        end
        S_WALK0: begin
          state <= (count == '0) ? S_DONE : S_WALK;
        end
        S_WALK: begin
          if (e_rdata[REM_MSB]) begin
            removed <= removed + 1'b1;
            count   <= count - 1'b1;
            if (count == CNT_W'(1)) begin
              head  <= '0;
              tail  <= '0;
              state <= S_DONE;
            end else begin
              head <= l_rdata;
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_SRCH: begin
          if (pend && !e_rdata[0]) begin
            put_slot <= pend_addr;
            state    <= S_PUT;
          end else if (idx < DEPTH_CNT) begin
            idx       <= idx + 1'b1;
            pend      <= 1'b1;
            pend_addr <= idx[IDX_W-1:0];
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_DONE;
            end
          end
        end
        S_PUT: begin
          acc   <= 1'b1;
          state <= S_DONE;
          if (first) begin
            head  <= '0;
            tail  <= '0;
            count <= CNT_W'(1);
          end else begin
            tail  <= put_slot;
            count <= count + 1'b1;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign item_ready = (state == S_IDLE);
  assign res_valid  = (state == S_DONE);

  assign slot_ext    = {{SLOT_W{1'b0}}, put_slot};
  assign head_ext    = {{SLOT_W{1'b0}}, (count != '0) ? head : {IDX_W{1'b0}}};
  assign removed_ext = {{COUNT_W{1'b0}}, removed};
  assign alive_ext   = {{COUNT_W{1'b0}}, count};

  always_comb begin
    res.accepted      = acc;
    res.slot          = slot_ext[SLOT_W-1:0];
    res.removed_count = removed_ext[COUNT_W-1:0];
    res.alive_count   = alive_ext[COUNT_W-1:0];
    res.head_valid    = (count != '0);
    res.head_slot     = head_ext[SLOT_W-1:0];
  end

endmodule

// ----- rtl/core/trail_point_fade_queue.sv -----
// ----------------------------------------------------------------------------
// trail_point_fade_queue
// pool of trail points linked in age order, each with a fade time; ticks
// age and expire points from the head, adds link new points at the tail
//
//   channel   direction  handshake            payload
//   s_*       in         s_tvalid / s_tready  tuser func, tdata dt and point
//   m_*       out        m_tvalid / m_tready  tdata result record
//   cfg_*     in         cfg_valid/cfg_ready  register index and value
//
// a tick sweeps the entry ram and checks the head, then unlinks each expired
// point from the head in turn; an add on an empty list writes the point at
// once, otherwise it first searches a free slot (one entry ram read per
// cycle). after reset a clearing pass over all POOL_DEPTH entries runs
// before the first transaction is taken. a finished result sits in the
// output register while the next item is taken; the sequencer holds at its
// end until that register is free.
// ----------------------------------------------------------------------------
module trail_point_fade_queue #(
  parameter int POOL_DEPTH  = tpfq_pkg::POOL_DEPTH_DEF,
  parameter int COORD_WIDTH = tpfq_pkg::COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // dt, pt_x, pt_y, pt_z
  input  logic [((tpfq_pkg::TIME_W + 3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  // func
  input  logic                                  s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // accepted, slot, removed_count, alive_count, head_valid, head_slot
  output logic [tpfq_pkg::OUT_DATA_W-1:0]       m_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tpfq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tpfq_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import tpfq_pkg::*;

  localparam int RES_W = $bits(result_t);

  logic [TIME_W-1:0] fade_time;
  logic [TIME_W-1:0] min_interval;
  logic              res_valid;
  logic              res_ready;
  result_t           res;
  result_t           out_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_time    <= FADE_TIME_RESET;
      min_interval <= MIN_INTERVAL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FADE_TIME:    fade_time    <= cfg_data[TIME_W-1:0];
        CFG_MIN_INTERVAL: min_interval <= cfg_data[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tpfq_seq #(
    .POOL_DEPTH  (POOL_DEPTH),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .fade_time    (fade_time),
    .min_interval (min_interval),
    .item_valid   (s_tvalid),
    .item_ready   (s_tready),
    .func         (s_tuser),
    .dt           (s_tdata[TIME_W-1:0]),
    .pt_x         (s_tdata[TIME_W +: COORD_WIDTH]),
    .pt_y         (s_tdata[TIME_W + COORD_WIDTH +: COORD_WIDTH]),
    .pt_z         (s_tdata[TIME_W + 2 * COORD_WIDTH +: COORD_WIDTH]),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_tdata = {{(OUT_DATA_W-RES_W){1'b0}}, out_q};

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the trail point fade queue: ticks and adds go in
// over the stream input, a scoreboard ages its own copy of the point pool and
// compares every status record on the stream output. it runs a directed
// opening, then random phases over several fade and interval settings, most
// of them with random gaps on the input and/or stalls on the output
// ----------------------------------------------------------------------------
module tb_top;
  import tpfq_pkg::*;

  localparam int POOL      = POOL_DEPTH_DEF;
  localparam int COORD_W   = COORD_WIDTH_DEF;
  localparam int IN_W      = ((TIME_W + 3 * COORD_W + 7) / 8) * 8;
  localparam int RES_W     = $bits(result_t);
  localparam int WATCHDOG  = 4000;
  localparam int REPORT_MAX = 10;
  localparam int PHASES    = 8;
  localparam int PHASE_LEN = 185;

  // index with no register behind it, writes must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = '1;
  localparam logic [TIME_W-1:0] DT_MAX = '1;
  localparam longint REM_FLOOR = -(longint'(1) <<< 32);

  class trail_queue_checker;
    logic [TIME_W-1:0]       fade_time;
    logic [TIME_W-1:0]       min_interval;
    logic signed [REM_W-1:0] remaining [POOL];
    logic [COUNT_W-1:0]      link_next [POOL];
    bit                      live [POOL];
    int unsigned             head;
    int unsigned             tail;
    int unsigned             count;
    logic [TIMER_W-1:0]      timer;
    result_t                 expected_status [$];
    int                      failures;
    int                      checked;
    int                      items;
    int                      stored;
    int                      full_drops;
    int                      expired;
    int                      peak;

    function new();
      fade_time = FADE_TIME_RESET;
      min_interval = MIN_INTERVAL_RESET;
      foreach (live[i]) live[i] = 1'b0;
      head = 0;
      tail = 0;
      count = 0;
      timer = '0;
      failures = 0;
      checked = 0;
      items = 0;
      stored = 0;
      full_drops = 0;
      expired = 0;
      peak = 0;
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FADE_TIME:    fade_time = data[TIME_W-1:0];
        CFG_MIN_INTERVAL: min_interval = data[TIME_W-1:0];
        default: ;
      endcase
    endfunction

    function void place_point(int unsigned s);
      remaining[s] = REM_W'(fade_time);
      link_next[s] = '0;
      live[s] = 1'b1;
      stored++;
    endfunction

    // ages or extends the pool and queues the status the block must report
    function void take_item(logic func, logic [TIME_W-1:0] dt);
      result_t      r;
      longint       rem;
      logic [TIMER_W:0] sum;
      int unsigned  s;
      int           i;
      r = '0;
      items++;
      if (func == FUNC_TICK) begin
        for (i = 0; i < POOL; i++) begin
          if (live[i]) begin
            rem = longint'(remaining[i]) - longint'(dt);
            if (rem < REM_FLOOR) rem = REM_FLOOR;
            remaining[i] = REM_W'(rem);
          end
        end
        // expired entries leave only from the head, so a dead one behind
        // a live head stays linked
        while (count > 0 && remaining[head] < 0) begin
          live[head] = 1'b0;
          count--;
          r.removed_count++;
          if (count == 0) begin
            head = 0;
            tail = 0;
          end else begin
            head = link_next[head] % POOL;
          end
        end
        expired += r.removed_count;
        sum = {1'b0, timer} + (TIMER_W + 1)'(dt);
        timer = sum[TIMER_W] ? '1 : sum[TIMER_W-1:0];
      end else if (timer >= min_interval || count == 0) begin
        timer = '0;
        if (count == 0) begin
          place_point(0);
          head = 0;
          tail = 0;
          count = 1;
          r.accepted = 1'b1;
        end else if (count < POOL) begin
          s = 0;
          while (live[s]) s++;
          place_point(s);
          link_next[tail] = COUNT_W'(s);
          tail = s;
          count++;
          r.accepted = 1'b1;
          r.slot = SLOT_W'(s);
        end else begin
          full_drops++;
        end
      end
      if (count > peak) peak = count;
      r.alive_count = COUNT_W'(count);
      r.head_valid = (count > 0);
      r.head_slot = (count > 0) ? SLOT_W'(head) : '0;
      expected_status.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("mismatch in %s of result %0d: expected %0d, got %0d",
                   name, checked, want, got);
      end
    endfunction

    function void check_status(logic [OUT_DATA_W-1:0] data);
      result_t want;
      result_t got;
      got = result_t'(data[RES_W-1:0]);
      if (expected_status.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("result with nothing outstanding: %h", data);
        return;
      end
      want = expected_status.pop_front();
      compare_field("accepted", want.accepted, got.accepted);
      compare_field("slot", want.slot, got.slot);
      compare_field("removed_count", want.removed_count, got.removed_count);
      compare_field("alive_count", want.alive_count, got.alive_count);
      compare_field("head_valid", want.head_valid, got.head_valid);
      compare_field("head_slot", want.head_slot, got.head_slot);
      compare_field("padding", 0, data[OUT_DATA_W-1:RES_W]);
      checked++;
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [IN_W-1:0]              s_tdata;
  logic                         s_tuser;
  logic                         m_tvalid;
  logic                         m_tready;
  logic [OUT_DATA_W-1:0]        m_tdata;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_data;

  trail_queue_checker chk;
  int gap_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  trail_point_fade_queue #(
    .POOL_DEPTH (POOL),
    .COORD_WIDTH(COORD_W)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // output side: check, pick the next ready, watch for a hang
  always @(posedge clk) begin
    if (m_tvalid && m_tready && !rst) chk.check_status(m_tdata);
    m_tready <= ($urandom_range(99) >= stall_pct);
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("no transaction for %0d cycles, %0d results outstanding",
               WATCHDOG, chk.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_item(input logic func, input logic [TIME_W-1:0] dt,
                           input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                           input logic [COORD_W-1:0] z);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 70)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= IN_W'({z, y, x, dt});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    chk.take_item(func, dt);
  endtask

  task automatic drain();
    while (chk.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    chk.write_reg(idx, data);
  endtask

  // callers drop s_tvalid before they come here
  task automatic set_regs(input logic [CFG_DATA_W-1:0] fade, input logic [CFG_DATA_W-1:0] interval);
    drain();
    write_reg(CFG_FADE_TIME, fade);
    write_reg(CFG_MIN_INTERVAL, interval);
    write_reg(CFG_NO_REG, $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(input int n, input int add_pct, input int span);
    logic              func;
    logic [TIME_W-1:0] dt;
    int                pick;
    for (int k = 0; k < n; k++) begin
      func = ($urandom_range(99) < add_pct) ? FUNC_ADD : FUNC_TICK;
      pick = $urandom_range(99);
      if (pick < 8)
        dt = '0;
      else if (pick < 16)
        dt = TIME_W'($urandom);
      else if (pick < 20)
        dt = (chk.fade_time > 2) ? chk.fade_time - TIME_W'($urandom_range(0, 2)) : chk.fade_time;
      else
        dt = TIME_W'($urandom_range(span));
      send_item(func, dt, $urandom, $urandom, $urandom);
    end
    s_tvalid <= 1'b0;
  endtask

  logic [CFG_DATA_W-1:0] fade_plan [PHASES] =
    '{32'h7fffffff, 32'd65536, 32'd0, 32'd1000, 32'd0, 32'hffffffff, 32'd1048576, 32'd0};
  logic [CFG_DATA_W-1:0] interval_plan [PHASES] =
    '{32'd0, 32'd1024, 32'h7fffffff, 32'd16, 32'd0, 32'hffffffff, 32'd0, 32'd0};
  int add_plan [PHASES]  = '{60, 50, 50, 70, 55, 50, 65, 50};
  int span_plan [PHASES] = '{4096, 4096, 65536, 64, 1024, 16777216, 16384, 1048576};

  initial begin
    chk = new();
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= FUNC_TICK;
    m_tready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: empty list, early add, zero remaining time, timer
    // saturation
    send_item(FUNC_TICK, '0, '0, '0, '0);
    send_item(FUNC_ADD, '0, 32'h80000000, 32'h7fffffff, 32'hffffffff);
    send_item(FUNC_ADD, DT_MAX, '0, '0, '0);
    send_item(FUNC_TICK, 31'd1024, '1, '1, '1);
    send_item(FUNC_ADD, '0, 32'h7fffffff, 32'h80000000, '0);
    send_item(FUNC_TICK, 31'd64512, '0, '0, '0);
    send_item(FUNC_TICK, 31'd1, '0, '0, '0);
    send_item(FUNC_TICK, DT_MAX, '0, '0, '0);
    send_item(FUNC_TICK, DT_MAX, '0, '0, '0);
    send_item(FUNC_TICK, DT_MAX, '0, '0, '0);
    send_item(FUNC_ADD, '0, 32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f);
    s_tvalid <= 1'b0;

    // a long-lived head with an already dead point queued behind it
    set_regs(32'h7fffffff, 32'd0);
    send_item(FUNC_ADD, '0, 32'h55555555, 32'haaaaaaaa, 32'h55555555);
    s_tvalid <= 1'b0;
    set_regs(32'd0, 32'd0);
    send_item(FUNC_ADD, '0, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa);
    send_item(FUNC_TICK, 31'd5, '0, '0, '0);
    send_item(FUNC_TICK, 31'd65536, '0, '0, '0);
    send_item(FUNC_TICK, 31'd2147418107, '0, '0, '0);
    send_item(FUNC_ADD, '0, '1, '0, '1);
    send_item(FUNC_ADD, '0, '0, '1, '0);
    send_item(FUNC_ADD, '0, '1, '1, '1);
    send_item(FUNC_TICK, '0, '0, '0, '0);
    send_item(FUNC_ADD, '0, '0, '0, '0);
    send_item(FUNC_TICK, 31'd1, '0, '0, '0);
    s_tvalid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 45; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 45; end
        default: begin gap_pct = 9; stall_pct = 9; end
      endcase
      if (p == 4) begin
        fade_plan[p] = $urandom_range(1 << 20);
        interval_plan[p] = $urandom_range(4096);
      end else if (p == 7) begin
        fade_plan[p] = $urandom;
        interval_plan[p] = {1'($urandom), 15'd0, 16'($urandom)};
      end
      set_regs(fade_plan[p], interval_plan[p]);
      run_random_phase(PHASE_LEN, add_plan[p], span_plan[p]);
    end

    drain();
    repeat (POOL + 16) @(posedge clk);
    if (chk.pending() != 0) begin
      chk.failures += chk.pending();
      $display("%0d results never arrived", chk.pending());
    end
    $display("%0d items in, %0d results checked, %0d mismatches over %0d settings",
             chk.items, chk.checked, chk.failures, PHASES + 3);
    $display("points stored %0d, dropped on a full pool %0d, expired %0d, peak occupancy %0d",
             chk.stored, chk.full_drops, chk.expired, chk.peak);
    if (chk.failures == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/tpfq_pkg.sv
rtl/core/tpfq_ram.sv
rtl/core/tpfq_seq.sv
rtl/core/trail_point_fade_queue.sv
tb/tb_top.sv
